// File: hw/rtl/mrbq_pkg.sv
// ----------------------------------------------------------------------------
// mrbq_pkg
// Shared constants, types and helpers of the multi-reader broadcast queue.
// ----------------------------------------------------------------------------
package mrbq_pkg;

    localparam int DEPTH   = 16;
    localparam int READERS = 2;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RD_W   = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CMD_W  = 1;
    localparam int RDR_W  = 1;
    localparam int ID_W   = 16;
    localparam int VAL_W  = 64;
    localparam int STP_W  = 64;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;
    localparam int REC_W  = ID_W + VAL_W + STP_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP    = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [READERS-1:0] t_marks;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic            insert;
        logic            pop;
        logic            ld_meta;
        logic            ld_data;
        logic [ST_W-1:0] status;
    } t_ctrl_cmd;

    typedef struct packed {
        logic full;
        logic no_data;
    } t_dp_stat;

    function automatic t_idx next_slot(input t_idx slot);
        return (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

endpackage

// File: hw/rtl/multi_reader_broadcast_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_reader_broadcast_queue_unit
// Ring of sensor records that every reader must read before it is freed.
// ----------------------------------------------------------------------------
// Request channel (i_valid/o_ready): i_cmd selects insert or pop; an insert
// carries sensor id, value and stamp, a pop names i_reader.
// Result channel (o_valid/i_ready): status, popped record (zero unless a
// pop succeeds) and the occupancy after the request.
// One request is in flight at a time. An insert or an empty pop presents its
// result in the cycle after the transfer; a successful pop passes through
// S_READ first, the registered read of the record RAM. The next request
// is taken in the cycle after the result transfer.
// A stalled receiver holds the result and keeps o_ready low.
// Reset clears the ring pointers, reader positions and read marks; the
// block takes requests in the first cycle after reset. Record RAM
// contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_queue_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mrbq_pkg::CMD_W-1:0] i_cmd,
    input  logic [mrbq_pkg::RDR_W-1:0] i_reader,
    input  logic [mrbq_pkg::ID_W-1:0]  i_sensor_id,
    input  logic [mrbq_pkg::VAL_W-1:0] i_value_bits,
    input  logic [mrbq_pkg::STP_W-1:0] i_stamp,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mrbq_pkg::ST_W-1:0]  o_status,
    output logic [mrbq_pkg::ID_W-1:0]  o_out_sensor_id,
    output logic [mrbq_pkg::VAL_W-1:0] o_out_value_bits,
    output logic [mrbq_pkg::STP_W-1:0] o_out_stamp,
    output logic [mrbq_pkg::OCC_W-1:0] o_occupancy
);
    import mrbq_pkg::*;

    t_ctrl_cmd cmd_ctl;
    t_dp_stat  dp_stat;

    mrbq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_stat    (dp_stat),
        .o_cmd_ctl (cmd_ctl)
    );

    mrbq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (cmd_ctl),
        .o_stat           (dp_stat),
        .i_reader         (i_reader),
        .i_sensor_id      (i_sensor_id),
        .i_value_bits     (i_value_bits),
        .i_stamp          (i_stamp),
        .o_status         (o_status),
        .o_out_sensor_id  (o_out_sensor_id),
        .o_out_value_bits (o_out_value_bits),
        .o_out_stamp      (o_out_stamp),
        .o_occupancy      (o_occupancy)
    );

endmodule

// File: hw/rtl/mrbq_ram.sv
// ----------------------------------------------------------------------------
// mrbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mrbq_datapath.sv
// ----------------------------------------------------------------------------
// mrbq_datapath
// Record store, read marks, ring and reader pointers, result register.
// ----------------------------------------------------------------------------
module mrbq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrbq_pkg::t_ctrl_cmd         i_cmd_ctl,
    output mrbq_pkg::t_dp_stat          o_stat,
    input  logic [mrbq_pkg::RDR_W-1:0]  i_reader,
    input  logic [mrbq_pkg::ID_W-1:0]   i_sensor_id,
    input  logic [mrbq_pkg::VAL_W-1:0]  i_value_bits,
    input  logic [mrbq_pkg::STP_W-1:0]  i_stamp,
    output logic [mrbq_pkg::ST_W-1:0]   o_status,
    output logic [mrbq_pkg::ID_W-1:0]   o_out_sensor_id,
    output logic [mrbq_pkg::VAL_W-1:0]  o_out_value_bits,
    output logic [mrbq_pkg::STP_W-1:0]  o_out_stamp,
    output logic [mrbq_pkg::OCC_W-1:0]  o_occupancy
);
    import mrbq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    t_marks r_marks [DEPTH];
    t_idx   r_oldest, n_oldest;
    t_cnt   r_count, n_count;
    t_idx   r_pos    [READERS];
    t_cnt   r_unread [READERS];

    logic [ST_W-1:0]  r_status;
    logic [ID_W-1:0]  r_id;
    logic [VAL_W-1:0] r_val;
    logic [STP_W-1:0] r_stp;
    logic [OCC_W-1:0] r_occ;

    logic [RD_W-1:0]  rd;
    logic             rd_ok;
    logic [SUM_W-1:0] sum;
    t_idx             slot_ins;
    t_idx             slot_pop;
    t_marks           rd_bit;
    t_marks           oldest_marks;
    logic             free_oldest;
    logic [REC_W-1:0] rec_rd;

    assign rd       = RD_W'(i_reader);
    assign rd_ok    = (32'(i_reader) < READERS);
    assign sum      = SUM_W'(r_oldest) + SUM_W'(r_count);
    assign slot_ins = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
    assign slot_pop = r_pos[rd];
    assign rd_bit   = t_marks'(1) << rd;

    assign o_stat.full    = (r_count >= CNT_W'(DEPTH));
    assign o_stat.no_data = !rd_ok || (r_unread[rd] == '0);

    always_comb begin
        oldest_marks = r_marks[r_oldest];
        if (slot_pop == r_oldest) begin
            oldest_marks = oldest_marks | rd_bit;
        end
        free_oldest = i_cmd_ctl.pop && (r_count != '0) && (&oldest_marks);
    end

    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        if (i_cmd_ctl.insert) begin
            n_count = r_count + 1'b1;
        end else if (free_oldest) begin
            n_oldest = next_slot(r_oldest);
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_marks[i] <= '0;
            end
            for (int r = 0; r < READERS; r++) begin
                r_pos[r]    <= '0;
                r_unread[r] <= '0;
            end
        end else begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (i_cmd_ctl.insert) begin
                r_marks[slot_ins] <= '0;
                for (int r = 0; r < READERS; r++) begin
                    r_unread[r] <= r_unread[r] + 1'b1;
                end
            end
            if (i_cmd_ctl.pop) begin
                r_marks[slot_pop] <= r_marks[slot_pop] | rd_bit;
                r_pos[rd]         <= next_slot(slot_pop);
                r_unread[rd]      <= r_unread[rd] - 1'b1;
            end
        end
    end

    mrbq_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd_ctl.insert),
        .i_waddr (slot_ins),
        .i_wdata ({i_sensor_id, i_value_bits, i_stamp}),
        .i_re    (i_cmd_ctl.pop),
        .i_raddr (slot_pop),
        .o_rdata (rec_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.ld_meta) begin
            r_status <= i_cmd_ctl.status;
            r_occ    <= OCC_W'(n_count);
            if (!i_cmd_ctl.pop) begin
                r_id  <= '0;
                r_val <= '0;
                r_stp <= '0;
            end
        end
        if (i_cmd_ctl.ld_data) begin
            {r_id, r_val, r_stp} <= rec_rd;
        end
    end

    assign o_status         = r_status;
    assign o_out_sensor_id  = r_id;
    assign o_out_value_bits = r_val;
    assign o_out_stamp      = r_stp;
    assign o_occupancy      = r_occ;

endmodule

// File: hw/rtl/mrbq_ctrl.sv
// ----------------------------------------------------------------------------
// mrbq_ctrl
// Sequencer: takes a request, waits on a pop's RAM read, presents the result.
// ----------------------------------------------------------------------------
module mrbq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mrbq_pkg::CMD_W-1:0] i_cmd,
    output logic                       o_valid,
    input  logic                       i_ready,
    input  mrbq_pkg::t_dp_stat         i_stat,
    output mrbq_pkg::t_ctrl_cmd        o_cmd_ctl
);
    import mrbq_pkg::*;

    t_state r_state, n_state;
    logic   pop_ok;

    assign pop_ok = (i_cmd == CMD_POP) && !i_stat.no_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = pop_ok ? S_READ : S_RESP;
                end
            end
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        o_cmd_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready           = 1'b1;
                o_cmd_ctl.ld_meta = i_valid;
                if (i_cmd == CMD_INSERT) begin
                    o_cmd_ctl.insert = i_valid && !i_stat.full;
                    o_cmd_ctl.status = i_stat.full ? ST_FULL : ST_OK;
                end else begin
                    o_cmd_ctl.pop    = i_valid && pop_ok;
                    o_cmd_ctl.status = i_stat.no_data ? ST_EMPTY : ST_OK;
                end
            end
            S_READ: o_cmd_ctl.ld_data = 1'b1;
            S_RESP: o_valid = 1'b1;
            default: o_cmd_ctl = '0;
        endcase
    end

endmodule
